// ----- src/tdp_pkg.sv -----
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared types for the trial-division primality tester: controller states
// and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tdp_pkg;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_DECIDE,
		ST_FINISH
	} tdp_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture a new number, divisor back to three
		logic restart;  // begin a division by the current divisor
		logic advance;  // move to the next odd divisor and begin dividing
		logic step;     // one restoring-division step
	} tdp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_small;  // number is zero or one
		logic is_two;    // number is two
		logic is_odd;    // low bit of the number
		logic div_last;  // this is the last step of the division
		logic q_below;   // quotient is below the divisor
		logic rem_zero;  // remainder is zero
	} tdp_status_t;

endpackage

// ----- src/trial_division_primality.sv -----
// ----------------------------------------------------------------------------
// trial_division_primality
// Tests one unsigned number per beat for primality by trial division with
// odd divisors, computed with a bit-serial restoring divider.
//
// Channel  Direction  Payload
// s_axis   in         tdata: value (VALUE_WIDTH bits, zero-padded to bytes)
// m_axis   out        tdata: is_prime (bit 0, zero-padded to 8 bits)
//
// Zero, one, two and even numbers are decided in the check state, without division.
// An odd number is divided by one odd trial divisor after another; the divider
// resolves one quotient bit per cycle, and the number k of divisors tried
// reaches about 2^(VALUE_WIDTH/2 - 1) for the largest primes of the width.
// Reset is asynchronous and active low. A new beat is taken while a result
// waits in the output register; a held result stalls only the final step.
// ----------------------------------------------------------------------------
module trial_division_primality
	import tdp_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // [VALUE_WIDTH-1:0] value
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [7:0]                           m_tdata   // [0] is_prime
);

	tdp_cmd_t    cmd;
	tdp_status_t status;
	logic        prime;

	// Controller.
	tdp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_prime  (prime),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath; bits above the value width are dropped.
	tdp_dpath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.value  (s_tdata[VALUE_WIDTH-1:0]),
		.cmd    (cmd),
		.status (status)
	);

	assign m_tdata = {7'b0, prime};

endmodule

// ----- src/tdp_dpath.sv -----
// ----------------------------------------------------------------------------
// tdp_dpath
// Datapath of the primality tester: holds the number, the odd trial divisor
// and a bit-serial restoring divider that yields quotient and remainder.
// ----------------------------------------------------------------------------
module tdp_dpath
	import tdp_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [VALUE_WIDTH-1:0] value,
	input  tdp_cmd_t               cmd,
	output tdp_status_t            status
);

	// The divisor never exceeds the square root of the number by more than
	// one odd step, so half the width plus one bit holds it.
	localparam int DivWidth = (VALUE_WIDTH + 1) / 2 + 1;
	localparam int CntWidth = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
	localparam logic [CntWidth-1:0] LastCnt = CntWidth'(VALUE_WIDTH - 1);
	localparam logic [DivWidth-1:0] FirstDiv = DivWidth'(3);
	localparam logic [DivWidth-1:0] DivStep = DivWidth'(2);

	logic [VALUE_WIDTH-1:0] value_q;
	logic [VALUE_WIDTH-1:0] shift_q;
	logic [DivWidth-1:0]    div_q;
	logic [DivWidth-1:0]    rem_q;
	logic [CntWidth-1:0]    cnt_q;

	logic [DivWidth:0]      trial;
	logic                   fits;
	logic [DivWidth-1:0]    rem_next;

	// One restoring step: bring down the next dividend bit and subtract if it fits.
	always_comb begin
		trial    = {rem_q, shift_q[VALUE_WIDTH-1]};
		fits     = trial >= {1'b0, div_q};
		rem_next = fits ? DivWidth'(trial - {1'b0, div_q}) : trial[DivWidth-1:0];
	end

	// Number, divisor, and divider registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			shift_q <= '0;
			div_q   <= FirstDiv;
			rem_q   <= '0;
			cnt_q   <= '0;
		end else if (cmd.load) begin
			value_q <= value;
			div_q   <= FirstDiv;
			rem_q   <= '0;
		end else if (cmd.restart || cmd.advance) begin
			shift_q <= value_q;
			rem_q   <= '0;
			cnt_q   <= '0;
			if (cmd.advance) begin
				div_q <= div_q + DivStep;
			end
		end else if (cmd.step) begin
			// The dividend shifts out at the top while quotient bits enter below.
			shift_q <= {shift_q[VALUE_WIDTH-2:0], fits};
			rem_q   <= rem_next;
			cnt_q   <= cnt_q + CntWidth'(1);
		end
	end

	// Status toward the controller.
	always_comb begin
		status.is_small = value_q <= VALUE_WIDTH'(1);
		status.is_two   = value_q == VALUE_WIDTH'(2);
		status.is_odd   = value_q[0];
		status.div_last = cnt_q == LastCnt;
		status.q_below  = shift_q < VALUE_WIDTH'(div_q);
		status.rem_zero = rem_q == '0;
	end

`ifndef SYNTHESIS
	// Trial divisors are always odd.
	a_div_odd: assert property (@(posedge clk) disable iff (!arst_n) div_q[0])
		else $error("trial divisor became even");

	// The partial remainder always stays below the divisor.
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n) rem_q < div_q)
		else $error("partial remainder not below divisor");
`endif

endmodule

// ----- src/tdp_ctrl.sv -----
// ----------------------------------------------------------------------------
// tdp_ctrl
// Controller of the primality tester: sequences the special-case check and
// the divisions, and holds the result in the output register.
// ----------------------------------------------------------------------------
module tdp_ctrl
	import tdp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic        m_prime,
	input  tdp_status_t status,
	output tdp_cmd_t    cmd
);

	tdp_state_t state_q;
	tdp_state_t state_next;
	logic       result_q;
	logic       result_set;
	logic       result_val;
	logic       out_load;
	logic       out_free;
	logic       out_valid_q;
	logic       out_prime_q;

	assign out_free = !out_valid_q || m_tready;

	// Next-state logic.
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_next = ST_CHECK;
			end
			ST_CHECK: begin
				if (status.is_small || status.is_two || !status.is_odd) begin
					state_next = ST_FINISH;
				end else begin
					state_next = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (status.div_last) state_next = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (status.q_below || status.rem_zero) begin
					state_next = ST_FINISH;
				end else begin
					state_next = ST_DIVIDE;
				end
			end
			ST_FINISH: begin
				if (out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Output logic: datapath commands and result capture.
	always_comb begin
		cmd        = '0;
		s_tready   = 1'b0;
		result_set = 1'b0;
		result_val = 1'b0;
		out_load   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_CHECK: begin
				if (status.is_small || status.is_two || !status.is_odd) begin
					result_set = 1'b1;
					result_val = status.is_two;
				end else begin
					cmd.restart = 1'b1;
				end
			end
			ST_DIVIDE: begin
				cmd.step = 1'b1;
			end
			ST_DECIDE: begin
				// Divisor past the square root means prime; zero remainder means composite.
				if (status.q_below) begin
					result_set = 1'b1;
					result_val = 1'b1;
				end else if (status.rem_zero) begin
					result_set = 1'b1;
					result_val = 1'b0;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			ST_FINISH: begin
				out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Result of the test under way.
	always_ff @(posedge clk) begin
		if (result_set) result_q <= result_val;
	end

	// Output register, so the next number can be taken while a result waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) out_prime_q <= result_q;
	end

	assign m_tvalid = out_valid_q;
	assign m_prime  = out_prime_q;

`ifndef SYNTHESIS
	// The last division step always leads to the decision.
	a_div_to_decide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE && status.div_last) |=> (state_q == ST_DECIDE))
		else $error("division did not end in decision");

	// At most one datapath command is issued per cycle.
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.restart, cmd.advance, cmd.step}))
		else $error("conflicting datapath commands");

	// A finished test always reaches the output register.
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid)
		else $error("finished result not presented");
`endif

endmodule

// ----- tb/trial_division_primality_check.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trial_division_primality_check
// Watches both streams of the primality tester. Every input beat gets its
// answer worked out by plain trial division and queued. Every output beat is
// compared against the oldest queued answer. The failure count and the
// number of answers still outstanding go back to the testbench top.
// ----------------------------------------------------------------------------
module trial_division_primality_check #(
	parameter int VALUE_WIDTH = 32,
	parameter int TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [TDATA_WIDTH-1:0] s_tdata,   // [VALUE_WIDTH-1:0] value
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [7:0]             m_tdata,   // [0] is_prime
	output int                     errors,
	output int                     pending
);

	// One outstanding answer: the number that went in and whether it is prime.
	typedef struct {
		logic [VALUE_WIDTH-1:0] value;
		logic                   is_prime;
	} primality_t;

	primality_t primality_q[$];

	// Trial division by odd divisors. The bound is written as d <= n / d so
	// that it cannot overflow at any value width.
	function automatic logic prime_by_trial(input logic [VALUE_WIDTH-1:0] value);
		longint unsigned n;
		longint unsigned d;
		n = value;
		if (n <= 1)
			return 1'b0;
		if (n == 2)
			return 1'b1;
		if ((n & 1) == 0)
			return 1'b0;
		for (d = 3; d <= n / d; d += 2) begin
			if (n % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Check output beats first, so that a beat entering in the same cycle can
	// never be matched against its own answer.
	always @(posedge clk or negedge arst_n) begin
		primality_t want;
		if (!arst_n) begin
			primality_q.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (primality_q.size() == 0) begin
					errors++;
					$display("%0t: result beat with no answer outstanding: expected none, got %02h",
						$time, m_tdata);
				end else begin
					want = primality_q.pop_front();
					if (m_tdata !== {7'b0, want.is_prime}) begin
						errors++;
						$display("%0t: is_prime for %0d: expected %02h, got %02h",
							$time, want.value, {7'b0, want.is_prime}, m_tdata);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				want.value    = s_tdata[VALUE_WIDTH-1:0];
				want.is_prime = prime_by_trial(want.value);
				primality_q.push_back(want);
			end
			pending <= primality_q.size();
		end
	end

endmodule

// ----- tb/trial_division_primality_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trial_division_primality_test
// Drives numbers into the primality tester and gives the verdict. Corner
// numbers come first, then a long receiver stall that backs up the input,
// then random numbers under three idling mixes. Values are kept to sizes
// whose trial division finishes in reasonable time; the checker beside the
// block predicts and compares every answer.
// ----------------------------------------------------------------------------
module trial_division_primality_test;

	localparam int VALUE_WIDTH      = 32;
	localparam int TDATA_WIDTH      = ((VALUE_WIDTH + 7) / 8) * 8;
	localparam int QUIET_LIMIT      = 600000;
	localparam int LONG_STALL       = 300;
	localparam int TAIL_CYCLES      = 64;
	localparam int RANDOM_PER_PHASE = 23;

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   s_tvalid    = 1'b0;
	logic [TDATA_WIDTH-1:0] s_tdata     = '0;
	logic                   m_tready    = 1'b0;
	logic                   stall_burst = 1'b0;
	logic                   s_tready;
	logic                   m_tvalid;
	logic [7:0]             m_tdata;
	int                     errors;
	int                     pending;
	int                     tx_idle_pct = 0;
	int                     rx_idle_pct = 0;
	int                     quiet_cycles = 0;
	logic [VALUE_WIDTH-1:0] corner_values[$];

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	trial_division_primality #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	trial_division_primality_check #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) results_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.errors  (errors),
		.pending (pending)
	);

	// Result side: random back-pressure, or one long hold when requested.
	always @(posedge clk) begin
		if (stall_burst) begin
			stall_burst <= 1'b0;
			m_tready <= 1'b0;
			repeat (LONG_STALL) @(posedge clk);
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Watchdog on cycles without any beat on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// True when trial division stops early: below two, even, with an odd factor
	// below 2048, or under about 2048 squared. Keeps full-width random numbers cheap.
	function automatic logic quick_to_test(input logic [VALUE_WIDTH-1:0] n);
		int unsigned d;
		if (n < 2 || !n[0])
			return 1'b1;
		for (d = 3; d < 2048; d += 2) begin
			if (d > n / d || n % d == 0)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// Mix of sizes: 16-bit, odd 20-bit, cheap full-width numbers, and
	// odd squares with their odd neighbors, where the divisor bound is tight.
	function automatic logic [VALUE_WIDTH-1:0] random_value();
		int unsigned            pick;
		int unsigned            d;
		logic [VALUE_WIDTH-1:0] v;
		pick = $urandom_range(99);
		if (pick < 35) begin
			v = $urandom_range(16'hFFFF);
		end else if (pick < 55) begin
			v = $urandom_range(20'hFFFFF) | 32'd1;
		end else if (pick < 80) begin
			do
				v = $urandom();
			while (!quick_to_test(v));
		end else begin
			d = 2 * $urandom_range(127) + 3;
			v = d * d + 2 * $urandom_range(2) - 2;
		end
		return v;
	endfunction

	// One input beat, after a random number of idle cycles. Valid stays high
	// between back-to-back beats.
	task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= $urandom();
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Stop offering beats until every answer has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	task automatic set_idling(input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct <= rx_pct;
	endtask

	initial begin
		corner_values = '{
			32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25, 32'd49,
			32'd121, 32'd63001, 32'd65521, 32'd65535, 32'd65537, 32'd1000003,
			32'd1022117, 32'd67108859, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000,
			32'h8000_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF
		};
		set_idling(22, 84);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Corner numbers: zero, one, two, even, odd squares, primes of
		// several sizes, and the all-zero and all-one patterns.
		foreach (corner_values[i])
			send_value(corner_values[i]);

		// Hold the result side while small numbers keep coming, so the
		// block fills up and refuses input.
		set_idling(0, 84);
		stall_burst <= 1'b1;
		repeat (8)
			send_value($urandom_range(255));
		drain_results();

		// Random numbers under three idling mixes.
		set_idling(22, 84);
		repeat (RANDOM_PER_PHASE)
			send_value(random_value());
		set_idling(84, 22);
		repeat (RANDOM_PER_PHASE)
			send_value(random_value());
		drain_results();
		set_idling(0, 0);
		repeat (RANDOM_PER_PHASE)
			send_value(random_value());

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- trial_division_primality.f -----
src/tdp_pkg.sv
src/tdp_dpath.sv
src/tdp_ctrl.sv
src/trial_division_primality.sv
tb/trial_division_primality_check.sv
tb/trial_division_primality_test.sv
